>>> design/camm_pkg.sv
// ----------------------------------------------------------------------------
// camm_pkg: shared definitions for the cascaded attitude motor mixer
// Widths, fixed-point constants, register indexes, mode codes, multiply
// operation codes and the command and status groups between the controller
// and the datapath.
// ----------------------------------------------------------------------------
package camm_pkg;

  // Fixed-point format and outer loop period.
  localparam int FRAC_BITS        = 10;
  localparam int OUTER_LOOP_TICKS = 2;

  // Field widths.
  localparam int JOY_W       = 11;
  localparam int SENS_W      = 18;
  localparam int GAIN_W      = 16;
  localparam int MODE_W      = 2;
  localparam int WORD_W      = 32;
  localparam int TICK_W      = 2;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = GAIN_W;

  // The shared multiplier takes a full word times a short positive operand.
  localparam int MUL_B_W = GAIN_W + 1;
  localparam int PROD_W  = WORD_W + MUL_B_W;

  // Fixed-point one.
  localparam logic [WORD_W-1:0] ONE = WORD_W'(1) << FRAC_BITS;

  // Control modes.
  localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd0;
  localparam logic [MODE_W-1:0] MODE_YAW    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FULL   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_ZERO   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_MODE       = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_YAW_GAIN   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_ANGLE_GAIN = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_RATE_GAIN  = 3'd3;

  // Configuration reset values.
  localparam logic [MODE_W-1:0] MODE_RESET       = MODE_ZERO;
  localparam logic [GAIN_W-1:0] YAW_GAIN_RESET   = 16'd24;
  localparam logic [GAIN_W-1:0] ANGLE_GAIN_RESET = 16'd75;
  localparam logic [GAIN_W-1:0] RATE_GAIN_RESET  = 16'd30;

  // Multiply operations issued by the controller.
  typedef logic [3:0] op_t;
  localparam op_t OP_NONE = 4'd0;
  localparam op_t OP_YAW  = 4'd1;
  localparam op_t OP_POUT = 4'd2;
  localparam op_t OP_PIN  = 4'd3;
  localparam op_t OP_ROUT = 4'd4;
  localparam op_t OP_RIN  = 4'd5;
  localparam op_t OP_M0   = 4'd6;
  localparam op_t OP_M1   = 4'd7;
  localparam op_t OP_M2   = 4'd8;
  localparam op_t OP_M3   = 4'd9;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    op_t  op;
  } camm_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              pitch_refresh;
    logic              roll_refresh;
    logic              out_busy;
  } camm_sts_t;

endpackage

>>> design/camm_ctrl.sv
// ----------------------------------------------------------------------------
// camm_ctrl: request sequencer
// Accepts a request, then issues the multiply operations that the current
// mode needs to the datapath, one per cycle, and finishes with the four
// motor products once the output register is free.
// ----------------------------------------------------------------------------
module camm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output camm_pkg::camm_cmd_t cmd,
  input  camm_pkg::camm_sts_t sts
);
  import camm_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  op_t        op;
  op_t        op_next;

  // State and current operation.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      op    <= OP_NONE;
    end else begin
      state <= state_next;
      op    <= op_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    op_next    = op;
    cmd.load   = 1'b0;
    cmd.op     = OP_NONE;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.mode == MODE_YAW || sts.mode == MODE_FULL) begin
            state_next = ST_RUN;
            op_next    = OP_YAW;
          end else begin
            state_next = ST_WAIT;
          end
        end
      end
      ST_RUN: begin
        cmd.op = op;
        case (op)
          OP_YAW: begin
            if (sts.mode == MODE_FULL) begin
              op_next = sts.pitch_refresh ? OP_POUT : OP_PIN;
            end else begin
              state_next = ST_WAIT;
            end
          end
          OP_POUT: op_next = OP_PIN;
          OP_PIN:  op_next = sts.roll_refresh ? OP_ROUT : OP_RIN;
          OP_ROUT: op_next = OP_RIN;
          OP_RIN:  state_next = ST_WAIT;
          OP_M0:   op_next = OP_M1;
          OP_M1:   op_next = OP_M2;
          OP_M2:   op_next = OP_M3;
          OP_M3: begin
            op_next    = OP_NONE;
            state_next = ST_IDLE;
          end
          default: begin
            op_next    = OP_NONE;
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_WAIT: begin
        // When a factor product is in flight, it lands during the first cycle of this state.
        if (!sts.out_busy) begin
          state_next = ST_RUN;
          op_next    = OP_M0;
        end
      end
      default: begin
        state_next = ST_IDLE;
        op_next    = OP_NONE;
      end
    endcase
  end

`ifndef SYNTHESIS
  // No request is taken while an operation is being issued.
  a_idle_no_op: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> cmd.op == OP_NONE)
    else $error("camm_ctrl: request accepted while issuing an operation");

  // Motor products start only into a free output register.
  a_m0_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_M0 |-> !sts.out_busy)
    else $error("camm_ctrl: motor products started over a pending result");

  // The last motor product always returns the sequencer to idle.
  a_m3_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.op == OP_M3 |=> state == ST_IDLE)
    else $error("camm_ctrl: sequencer did not return to idle");
`endif

endmodule

>>> design/camm_datapath.sv
// ----------------------------------------------------------------------------
// camm_datapath: registers, shared multiplier and result register
// Holds the configuration, the captured request, the yaw, pitch and roll
// factors and the loop state. One shared multiplier is fed by the issued
// operation; its product is registered with its operation tag and then folded
// into the factors, the held desired rates or the motor outputs.
// ----------------------------------------------------------------------------
module camm_datapath (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_we,
  input  logic        [camm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic        [camm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic        [camm_pkg::JOY_W-1:0]        joy_lift,
  input  logic signed [camm_pkg::JOY_W-1:0]        joy_yaw,
  input  logic signed [camm_pkg::JOY_W-1:0]        joy_pitch,
  input  logic signed [camm_pkg::JOY_W-1:0]        joy_roll,
  input  logic signed [camm_pkg::SENS_W-1:0]       yaw_rate,
  input  logic signed [camm_pkg::SENS_W-1:0]       roll_rate,
  input  logic signed [camm_pkg::SENS_W-1:0]       pitch_rate,
  input  logic signed [camm_pkg::SENS_W-1:0]       pitch_angle,
  input  logic signed [camm_pkg::SENS_W-1:0]       roll_angle,
  input  camm_pkg::camm_cmd_t                      cmd,
  output camm_pkg::camm_sts_t                      sts,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [camm_pkg::WORD_W-1:0]       motor_front,
  output logic signed [camm_pkg::WORD_W-1:0]       motor_right,
  output logic signed [camm_pkg::WORD_W-1:0]       motor_back,
  output logic signed [camm_pkg::WORD_W-1:0]       motor_left
);
  import camm_pkg::*;

  // Configuration registers.
  logic [MODE_W-1:0] control_mode;
  logic [GAIN_W-1:0] yaw_rate_gain;
  logic [GAIN_W-1:0] angle_gain;
  logic [GAIN_W-1:0] rate_gain;

  // Captured request.
  logic [JOY_W-1:0]  lift;
  logic [WORD_W-1:0] jp_word;
  logic [WORD_W-1:0] jr_word;
  logic [SENS_W-1:0] yr;
  logic [SENS_W-1:0] rr;
  logic [SENS_W-1:0] pr;
  logic [SENS_W-1:0] pa;
  logic [SENS_W-1:0] ra;

  // Factors and loop state.
  logic [WORD_W-1:0] fy;
  logic [WORD_W-1:0] fp;
  logic [WORD_W-1:0] fr;
  logic [TICK_W-1:0] pitch_tick_count;
  logic [TICK_W-1:0] roll_tick_count;
  logic [WORD_W-1:0] desired_pitch_rate;
  logic [WORD_W-1:0] desired_roll_rate;
  logic              pitch_refresh;
  logic              roll_refresh;

  // Multiplier.
  logic signed [WORD_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  product;
  logic [WORD_W-1:0]         prod_res;
  op_t                       prod_op;

  // Sign-extended joystick words used at capture.
  logic [WORD_W-1:0] jy_in;
  logic [WORD_W-1:0] jp_in;
  logic [WORD_W-1:0] jr_in;

  assign jy_in = {{(WORD_W-JOY_W){joy_yaw[JOY_W-1]}}, joy_yaw};
  assign jp_in = {{(WORD_W-JOY_W){joy_pitch[JOY_W-1]}}, joy_pitch};
  assign jr_in = {{(WORD_W-JOY_W){joy_roll[JOY_W-1]}}, joy_roll};

  assign pitch_refresh = pitch_tick_count >= TICK_W'(OUTER_LOOP_TICKS);
  assign roll_refresh  = roll_tick_count >= TICK_W'(OUTER_LOOP_TICKS);

  assign sts.mode          = control_mode;
  assign sts.pitch_refresh = pitch_refresh;
  assign sts.roll_refresh  = roll_refresh;
  assign sts.out_busy      = out_valid;

  // Configuration writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      control_mode  <= MODE_RESET;
      yaw_rate_gain <= YAW_GAIN_RESET;
      angle_gain    <= ANGLE_GAIN_RESET;
      rate_gain     <= RATE_GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:       control_mode  <= cfg_data[MODE_W-1:0];
        CFG_YAW_GAIN:   yaw_rate_gain <= cfg_data;
        CFG_ANGLE_GAIN: angle_gain    <= cfg_data;
        CFG_RATE_GAIN:  rate_gain     <= cfg_data;
        default: ;
      endcase
    end
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_YAW: begin
        mul_a = {{(WORD_W-SENS_W){yr[SENS_W-1]}}, yr};
        mul_b = {1'b0, yaw_rate_gain};
      end
      OP_POUT: begin
        mul_a = {{(WORD_W-SENS_W){pa[SENS_W-1]}}, pa};
        mul_b = {1'b0, angle_gain};
      end
      OP_PIN: begin
        mul_a = {{(WORD_W-SENS_W){pr[SENS_W-1]}}, pr};
        mul_b = {1'b0, rate_gain};
      end
      OP_ROUT: begin
        mul_a = {{(WORD_W-SENS_W){ra[SENS_W-1]}}, ra};
        mul_b = {1'b0, angle_gain};
      end
      OP_RIN: begin
        mul_a = {{(WORD_W-SENS_W){rr[SENS_W-1]}}, rr};
        mul_b = {1'b0, rate_gain};
      end
      OP_M0: begin
        mul_a = ONE - fy + fp;
        mul_b = {{(MUL_B_W-JOY_W){1'b0}}, lift};
      end
      OP_M1: begin
        mul_a = ONE + fy - fr;
        mul_b = {{(MUL_B_W-JOY_W){1'b0}}, lift};
      end
      OP_M2: begin
        mul_a = ONE - fy - fp;
        mul_b = {{(MUL_B_W-JOY_W){1'b0}}, lift};
      end
      OP_M3: begin
        mul_a = ONE + fy + fr;
        mul_b = {{(MUL_B_W-JOY_W){1'b0}}, lift};
      end
      default: ;
    endcase
  end

  assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Product register: arithmetic shift by the fraction, wrapped to a word.
  always_ff @(posedge clk) begin
    prod_res <= product[FRAC_BITS+WORD_W-1:FRAC_BITS];
  end

  // Operation tag that travels with the product.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_op <= OP_NONE;
    end else begin
      prod_op <= cmd.op;
    end
  end

  // Request capture and factor updates.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lift    <= joy_lift;
      jp_word <= jp_in;
      jr_word <= jr_in;
      yr      <= yaw_rate;
      rr      <= roll_rate;
      pr      <= pitch_rate;
      pa      <= pitch_angle;
      ra      <= roll_angle;
      fy      <= (control_mode == MODE_ZERO) ? '0 : jy_in;
      fp      <= (control_mode == MODE_MANUAL || control_mode == MODE_YAW) ? jp_in : '0;
      fr      <= (control_mode == MODE_MANUAL || control_mode == MODE_YAW) ? jr_in : '0;
    end
    case (prod_op)
      OP_YAW:  fy <= fy - prod_res;
      OP_PIN:  fp <= desired_pitch_rate - prod_res;
      OP_RIN:  fr <= desired_roll_rate + prod_res;
      default: ;
    endcase
  end

  // Held desired rates and outer loop tick counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      desired_pitch_rate <= '0;
      desired_roll_rate  <= '0;
      pitch_tick_count   <= '0;
      roll_tick_count    <= '0;
    end else begin
      case (prod_op)
        OP_POUT: desired_pitch_rate <= (jp_word << 1) - prod_res;
        OP_ROUT: desired_roll_rate  <= (jr_word << 1) + prod_res;
        OP_PIN: begin
          pitch_tick_count <= pitch_refresh ? TICK_W'(1) : pitch_tick_count + TICK_W'(1);
        end
        OP_RIN: begin
          roll_tick_count <= roll_refresh ? TICK_W'(1) : roll_tick_count + TICK_W'(1);
        end
        default: ;
      endcase
    end
  end

  // Motor result register.
  always_ff @(posedge clk) begin
    case (prod_op)
      OP_M0:   motor_front <= prod_res;
      OP_M1:   motor_right <= prod_res;
      OP_M2:   motor_back  <= prod_res;
      OP_M3:   motor_left  <= prod_res;
      default: ;
    endcase
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (prod_op == OP_M3) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  // A motor product never overwrites a result that is still pending.
  a_no_clobber: assert property (@(posedge clk) disable iff (rst)
    (prod_op == OP_M0 || prod_op == OP_M1 || prod_op == OP_M2 || prod_op == OP_M3)
    |-> !out_valid)
    else $error("camm_datapath: motor result overwritten while pending");

  // After an inner pitch update the tick counter is never zero.
  a_pitch_tick: assert property (@(posedge clk) disable iff (rst)
    prod_op == OP_PIN |=> pitch_tick_count != '0)
    else $error("camm_datapath: pitch tick counter wrapped");

  // The inner pitch product always follows the yaw or outer pitch product.
  a_pin_order: assert property (@(posedge clk) disable iff (rst)
    prod_op == OP_PIN |-> ($past(prod_op) == OP_YAW || $past(prod_op) == OP_POUT))
    else $error("camm_datapath: inner pitch product out of order");
`endif

endmodule

>>> design/cascaded_attitude_motor_mixer.sv
// Sequencing: a new request is taken only after the previous one has issued its
// motor products, all through the single shared multiplier; yaw control adds the
// yaw product, full control adds the pitch and roll products, and each outer loop
// refresh adds one more. Motor products wait until the last result is taken.
// Reset: synchronous; registers return to mode 3 and the default gains, the
// held desired rates and tick counters clear, and no result is pending.
// ----------------------------------------------------------------------------
// cascaded_attitude_motor_mixer: cascaded attitude controller and quad mixer
// Takes joystick values and filtered attitude readings per control tick and
// returns four motor drive values, using a sequencer and a shared datapath.
// ----------------------------------------------------------------------------
module cascaded_attitude_motor_mixer (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_we,
  input  logic        [camm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic        [camm_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic        [camm_pkg::JOY_W-1:0]        joy_lift,
  input  logic signed [camm_pkg::JOY_W-1:0]        joy_yaw,
  input  logic signed [camm_pkg::JOY_W-1:0]        joy_pitch,
  input  logic signed [camm_pkg::JOY_W-1:0]        joy_roll,
  input  logic signed [camm_pkg::SENS_W-1:0]       yaw_rate,
  input  logic signed [camm_pkg::SENS_W-1:0]       roll_rate,
  input  logic signed [camm_pkg::SENS_W-1:0]       pitch_rate,
  input  logic signed [camm_pkg::SENS_W-1:0]       pitch_angle,
  input  logic signed [camm_pkg::SENS_W-1:0]       roll_angle,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [camm_pkg::WORD_W-1:0]       motor_front,
  output logic signed [camm_pkg::WORD_W-1:0]       motor_right,
  output logic signed [camm_pkg::WORD_W-1:0]       motor_back,
  output logic signed [camm_pkg::WORD_W-1:0]       motor_left
);
  import camm_pkg::*;

  camm_cmd_t cmd;
  camm_sts_t sts;

  // Sequencer.
  camm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Datapath.
  camm_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .joy_lift    (joy_lift),
    .joy_yaw     (joy_yaw),
    .joy_pitch   (joy_pitch),
    .joy_roll    (joy_roll),
    .yaw_rate    (yaw_rate),
    .roll_rate   (roll_rate),
    .pitch_rate  (pitch_rate),
    .pitch_angle (pitch_angle),
    .roll_angle  (roll_angle),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .motor_front (motor_front),
    .motor_right (motor_right),
    .motor_back  (motor_back),
    .motor_left  (motor_left)
  );

endmodule

>>> tb/camm_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// camm_checker: prediction and comparison for the attitude motor mixer
// Follows configuration writes and accepted requests and keeps its own copy of
// the gains, mode, tick counters and held desired rates. For every request it
// predicts the four motor drives, then compares each result against the oldest
// prediction, one field at a time.
// ----------------------------------------------------------------------------
module camm_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [camm_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [camm_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic [camm_pkg::JOY_W-1:0]          joy_lift,
  input  logic signed [camm_pkg::JOY_W-1:0]   joy_yaw,
  input  logic signed [camm_pkg::JOY_W-1:0]   joy_pitch,
  input  logic signed [camm_pkg::JOY_W-1:0]   joy_roll,
  input  logic signed [camm_pkg::SENS_W-1:0]  yaw_rate,
  input  logic signed [camm_pkg::SENS_W-1:0]  roll_rate,
  input  logic signed [camm_pkg::SENS_W-1:0]  pitch_rate,
  input  logic signed [camm_pkg::SENS_W-1:0]  pitch_angle,
  input  logic signed [camm_pkg::SENS_W-1:0]  roll_angle,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [camm_pkg::WORD_W-1:0]  motor_front,
  input  logic signed [camm_pkg::WORD_W-1:0]  motor_right,
  input  logic signed [camm_pkg::WORD_W-1:0]  motor_back,
  input  logic signed [camm_pkg::WORD_W-1:0]  motor_left,
  output int                                  mismatch_count,
  output int                                  drives_pending,
  output int                                  drives_checked
);
  import camm_pkg::*;

  typedef struct {
    logic signed [WORD_W-1:0] front;
    logic signed [WORD_W-1:0] right;
    logic signed [WORD_W-1:0] back;
    logic signed [WORD_W-1:0] left;
  } drive_set_t;

  // Shadow of the configuration registers.
  logic [MODE_W-1:0] mode_q;
  logic [GAIN_W-1:0] yaw_gain_q;
  logic [GAIN_W-1:0] angle_gain_q;
  logic [GAIN_W-1:0] rate_gain_q;

  // Shadow of the cascaded loop state.
  logic [TICK_W-1:0]        pitch_ticks;
  logic [TICK_W-1:0]        roll_ticks;
  logic signed [WORD_W-1:0] held_pitch_rate;
  logic signed [WORD_W-1:0] held_roll_rate;

  drive_set_t expected_drives[$];

  // Full signed product, shifted right arithmetically, wrapped to a word.
  function automatic logic signed [WORD_W-1:0] fx_mul(input logic signed [WORD_W-1:0] a,
                                                      input logic signed [WORD_W-1:0] b);
    logic signed [2*WORD_W-1:0] prod;
    prod = (2*WORD_W)'(a) * (2*WORD_W)'(b);
    return prod[FRAC_BITS +: WORD_W];
  endfunction

  function automatic logic signed [WORD_W-1:0] gain_word(input logic [GAIN_W-1:0] g);
    return $signed({{(WORD_W-GAIN_W){1'b0}}, g});
  endfunction

  // Works out the motor drives of the request on the ports and advances the
  // loop state the same way the block does.
  function automatic drive_set_t mix_tick();
    logic signed [WORD_W-1:0] lift;
    logic signed [WORD_W-1:0] jy;
    logic signed [WORD_W-1:0] jp;
    logic signed [WORD_W-1:0] jr;
    logic signed [WORD_W-1:0] fy;
    logic signed [WORD_W-1:0] fp;
    logic signed [WORD_W-1:0] fr;
    logic signed [WORD_W-1:0] one;
    drive_set_t d;
    lift = $signed({{(WORD_W-JOY_W){1'b0}}, joy_lift});
    jy = WORD_W'(joy_yaw);
    jp = WORD_W'(joy_pitch);
    jr = WORD_W'(joy_roll);
    one = ONE;
    fy = '0;
    fp = '0;
    fr = '0;
    case (mode_q)
      MODE_MANUAL: begin
        fy = jy;
        fp = jp;
        fr = jr;
      end
      MODE_YAW: begin
        fy = jy - fx_mul(WORD_W'(yaw_rate), gain_word(yaw_gain_q));
        fp = jp;
        fr = jr;
      end
      MODE_FULL: begin
        fy = jy - fx_mul(WORD_W'(yaw_rate), gain_word(yaw_gain_q));
        // The outer angle loop refreshes the held rate once every OUTER_LOOP_TICKS ticks.
        if (pitch_ticks >= TICK_W'(OUTER_LOOP_TICKS)) begin
          held_pitch_rate = jp + jp - fx_mul(WORD_W'(pitch_angle), gain_word(angle_gain_q));
          pitch_ticks = '0;
        end
        fp = held_pitch_rate - fx_mul(WORD_W'(pitch_rate), gain_word(rate_gain_q));
        pitch_ticks = pitch_ticks + TICK_W'(1);
        // Roll mirrors pitch with the signs of the gain terms flipped.
        if (roll_ticks >= TICK_W'(OUTER_LOOP_TICKS)) begin
          held_roll_rate = jr + jr + fx_mul(WORD_W'(roll_angle), gain_word(angle_gain_q));
          roll_ticks = '0;
        end
        fr = held_roll_rate + fx_mul(WORD_W'(roll_rate), gain_word(rate_gain_q));
        roll_ticks = roll_ticks + TICK_W'(1);
      end
      default: begin
      end
    endcase
    d.front = fx_mul(lift, one - fy + fp);
    d.right = fx_mul(lift, one + fy - fr);
    d.back  = fx_mul(lift, one - fy - fp);
    d.left  = fx_mul(lift, one + fy + fr);
    return d;
  endfunction

  task automatic check_drive(input string name, input logic signed [WORD_W-1:0] want,
                             input logic signed [WORD_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Track writes, predict on each request, compare on each result.
  always @(posedge clk) begin
    drive_set_t want;
    if (rst) begin
      mode_q          = MODE_RESET;
      yaw_gain_q      = YAW_GAIN_RESET;
      angle_gain_q    = ANGLE_GAIN_RESET;
      rate_gain_q     = RATE_GAIN_RESET;
      pitch_ticks     = '0;
      roll_ticks      = '0;
      held_pitch_rate = '0;
      held_roll_rate  = '0;
      expected_drives.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE:       mode_q = cfg_data[MODE_W-1:0];
          CFG_YAW_GAIN:   yaw_gain_q = cfg_data;
          CFG_ANGLE_GAIN: angle_gain_q = cfg_data;
          CFG_RATE_GAIN:  rate_gain_q = cfg_data;
          default: begin
          end
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_drives.size() == 0) begin
          $error("motor drives: result arrived with no request outstanding");
          mismatch_count++;
        end else begin
          want = expected_drives.pop_front();
          check_drive("motor_front", want.front, motor_front);
          check_drive("motor_right", want.right, motor_right);
          check_drive("motor_back", want.back, motor_back);
          check_drive("motor_left", want.left, motor_left);
          drives_checked++;
        end
      end
      if (in_valid && in_ready) begin
        expected_drives.push_back(mix_tick());
      end
    end
    drives_pending = expected_drives.size();
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: top-level test of the cascaded attitude motor mixer
// Drives control ticks through the request channel under several settings of
// mode and gains, with random sender gaps and receiver stalls, and lets the
// checker predict and compare the motor drives. Reports the verdict.
// ----------------------------------------------------------------------------
module tb;
  import camm_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_TICKS    = 150;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [JOY_W-1:0]         joy_lift = '0;
  logic signed [JOY_W-1:0]  joy_yaw = '0;
  logic signed [JOY_W-1:0]  joy_pitch = '0;
  logic signed [JOY_W-1:0]  joy_roll = '0;
  logic signed [SENS_W-1:0] yaw_rate = '0;
  logic signed [SENS_W-1:0] roll_rate = '0;
  logic signed [SENS_W-1:0] pitch_rate = '0;
  logic signed [SENS_W-1:0] pitch_angle = '0;
  logic signed [SENS_W-1:0] roll_angle = '0;

  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic signed [WORD_W-1:0] motor_front;
  logic signed [WORD_W-1:0] motor_right;
  logic signed [WORD_W-1:0] motor_back;
  logic signed [WORD_W-1:0] motor_left;

  int mismatch_count;
  int drives_pending;
  int drives_checked;

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int ticks_sent = 0;
  int quiet_cycles = 0;

  // Clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  cascaded_attitude_motor_mixer u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .joy_lift    (joy_lift),
    .joy_yaw     (joy_yaw),
    .joy_pitch   (joy_pitch),
    .joy_roll    (joy_roll),
    .yaw_rate    (yaw_rate),
    .roll_rate   (roll_rate),
    .pitch_rate  (pitch_rate),
    .pitch_angle (pitch_angle),
    .roll_angle  (roll_angle),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .motor_front (motor_front),
    .motor_right (motor_right),
    .motor_back  (motor_back),
    .motor_left  (motor_left)
  );

  camm_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .joy_lift       (joy_lift),
    .joy_yaw        (joy_yaw),
    .joy_pitch      (joy_pitch),
    .joy_roll       (joy_roll),
    .yaw_rate       (yaw_rate),
    .roll_rate      (roll_rate),
    .pitch_rate     (pitch_rate),
    .pitch_angle    (pitch_angle),
    .roll_angle     (roll_angle),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .motor_front    (motor_front),
    .motor_right    (motor_right),
    .motor_back     (motor_back),
    .motor_left     (motor_left),
    .mismatch_count (mismatch_count),
    .drives_pending (drives_pending),
    .drives_checked (drives_checked)
  );

  // Receiver side: random stalls at the rate of the current phase.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("cascaded_attitude_motor_mixer test failed");
      $finish;
    end
  end

  // One control tick request; valid stays high until the block takes it.
  task automatic send_tick(input logic [JOY_W-1:0] lift, input logic [JOY_W-1:0] jy,
                           input logic [JOY_W-1:0] jp, input logic [JOY_W-1:0] jr,
                           input logic [SENS_W-1:0] yr, input logic [SENS_W-1:0] rr,
                           input logic [SENS_W-1:0] pr, input logic [SENS_W-1:0] pa,
                           input logic [SENS_W-1:0] ra);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    joy_lift    <= lift;
    joy_yaw     <= jy;
    joy_pitch   <= jp;
    joy_roll    <= jr;
    yaw_rate    <= yr;
    roll_rate   <= rr;
    pitch_rate  <= pr;
    pitch_angle <= pa;
    roll_angle  <= ra;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ticks_sent++;
  endtask

  // Hold off new requests until every predicted result has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (drives_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // The upper bits of the mode word are random; only the low bits count.
  task automatic set_config(input logic [MODE_W-1:0] mode, input logic [GAIN_W-1:0] yaw_gain,
                            input logic [GAIN_W-1:0] angle_gain,
                            input logic [GAIN_W-1:0] rate_gain);
    logic [CFG_DATA_W-1:0] mode_word;
    mode_word = CFG_DATA_W'($urandom);
    mode_word[MODE_W-1:0] = mode;
    write_reg(CFG_MODE, mode_word);
    write_reg(CFG_YAW_GAIN, yaw_gain);
    write_reg(CFG_ANGLE_GAIN, angle_gain);
    write_reg(CFG_RATE_GAIN, rate_gain);
  endtask

  function automatic logic [JOY_W-1:0] rand_lift();
    case ($urandom_range(5))
      0:       return JOY_W'($urandom);
      1:       return ($urandom_range(1) != 0) ? 11'd1024 : 11'd0;
      default: return JOY_W'($urandom_range(1024));
    endcase
  endfunction

  function automatic logic [JOY_W-1:0] rand_stick();
    if ($urandom_range(7) == 0) begin
      return JOY_W'($urandom);
    end
    return JOY_W'($urandom_range(1024) - 512);
  endfunction

  function automatic logic [SENS_W-1:0] rand_sensor();
    case ($urandom_range(5))
      0, 1:    return SENS_W'($urandom);
      2:       return ($urandom_range(1) != 0) ? 18'h1FFFF : 18'h20000;
      default: return SENS_W'($urandom_range(4096) - 2048);
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random_tick();
    send_tick(rand_lift(), rand_stick(), rand_stick(), rand_stick(), rand_sensor(),
              rand_sensor(), rand_sensor(), rand_sensor(), rand_sensor());
  endtask

  // Sender gap and receiver stall rates for each pressure pattern.
  task automatic set_pressure(input int pattern);
    case (pattern % 4)
      0: begin
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
      end
      1: begin
        sender_idle_pct = 75;
        receiver_stall_pct = 0;
      end
      2: begin
        sender_idle_pct = 0;
        receiver_stall_pct = 75;
      end
      default: begin
        sender_idle_pct = 21;
        receiver_stall_pct = 21;
      end
    endcase
  endtask

  // Stimulus and verdict.
  initial begin
    logic [MODE_W-1:0] mode;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration: attitude factors zero, lift at its extremes.
    send_tick(11'd2047, 11'h400, 11'h3FF, 11'h400, 18'h1FFFF, 18'h20000, 18'h1FFFF,
              18'h20000, 18'h1FFFF);
    send_tick(11'd0, 11'h3FF, 11'h400, 11'h3FF, 18'h20000, 18'h1FFFF, 18'h20000,
              18'h1FFFF, 18'h20000);

    // Manual mode passes the joystick through.
    wait_idle();
    set_config(MODE_MANUAL, YAW_GAIN_RESET, ANGLE_GAIN_RESET, RATE_GAIN_RESET);
    send_tick(11'd1024, -11'sd512, 11'sd512, -11'sd512, '0, '0, '0, '0, '0);
    send_tick(11'd2047, 11'h3FF, 11'h400, 11'h3FF, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF,
              18'h1FFFF, 18'h1FFFF);
    send_tick(11'd1024, 11'sd512, -11'sd512, 11'sd512, '0, '0, '0, '0, '0);

    // Yaw control with the yaw rate at both extremes.
    wait_idle();
    set_config(MODE_YAW, YAW_GAIN_RESET, ANGLE_GAIN_RESET, RATE_GAIN_RESET);
    send_tick(11'd1024, 11'sd100, -11'sd100, 11'sd50, 18'h20000, 18'h100, 18'h200, 18'h300,
              18'h400);
    send_tick(11'd512, -11'sd512, '0, '0, 18'h1FFFF, '0, '0, '0, '0);

    // Full control from reset: the held rates start at zero, then refresh.
    wait_idle();
    set_config(MODE_FULL, YAW_GAIN_RESET, ANGLE_GAIN_RESET, RATE_GAIN_RESET);
    repeat (5) send_tick(11'd1024, rand_stick(), rand_stick(), rand_stick(), rand_sensor(),
                         rand_sensor(), rand_sensor(), rand_sensor(), rand_sensor());

    // Loop counters and held rates must survive a detour through yaw control.
    wait_idle();
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_YAW));
    send_random_tick();
    wait_idle();
    write_reg(CFG_MODE, CFG_DATA_W'(MODE_FULL));
    send_random_tick();
    send_random_tick();

    // Largest gains with extreme readings.
    wait_idle();
    set_config(MODE_FULL, '1, '1, '1);
    send_tick(11'd2047, 11'h3FF, 11'h400, 11'h3FF, 18'h20000, 18'h1FFFF, 18'h20000,
              18'h1FFFF, 18'h20000);
    send_tick(11'd2047, 11'h400, 11'h3FF, 11'h400, 18'h1FFFF, 18'h20000, 18'h1FFFF,
              18'h20000, 18'h1FFFF);
    send_tick(11'd1024, 11'sd512, 11'sd512, -11'sd512, 18'h1FFFF, 18'h1FFFF, 18'h20000,
              18'h20000, 18'h1FFFF);

    // Zero gains, then writes beyond the register list must change nothing.
    wait_idle();
    set_config(MODE_FULL, '0, '0, '0);
    send_random_tick();
    send_random_tick();
    wait_idle();
    for (int i = int'(CFG_RATE_GAIN) + 1; i < 2 ** CFG_INDEX_W; i++) begin
      write_reg(i[CFG_INDEX_W-1:0], CFG_DATA_W'($urandom));
    end
    send_random_tick();

    // Random phases, every other one in full control so the cascaded loops run deep.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      if (p % 2 == 0) begin
        mode = MODE_FULL;
      end else begin
        case ((p / 2) % 4)
          0:       mode = MODE_MANUAL;
          1:       mode = MODE_YAW;
          2:       mode = MODE_ZERO;
          default: mode = MODE_W'($urandom_range(3));
        endcase
      end
      if (p == 4) begin
        set_config(mode, '1, '1, '1);
      end else if (p == 8) begin
        set_config(mode, '0, '0, '0);
      end else begin
        set_config(mode, rand_gain(), rand_gain(), rand_gain());
      end
      set_pressure(p);
      for (int n = 0; n < PHASE_TICKS; n++) begin
        if ($urandom_range(199) == 0) begin
          wait_idle();
        end
        send_random_tick();
      end
    end

    // Drain, then allow for the block's latency.
    set_pressure(0);
    wait_idle();
    repeat (16) @(posedge clk);

    $display("Run summary: %0d control ticks in all four modes, directed extremes plus %0d",
             ticks_sent, RANDOM_PHASES);
    $display("  random phases with gaps and stalls; %0d drive sets compared, %0d mismatches.",
             drives_checked, mismatch_count);
    if (mismatch_count == 0 && drives_pending == 0) begin
      $display("cascaded_attitude_motor_mixer test passed");
    end else begin
      $display("cascaded_attitude_motor_mixer test failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/camm_pkg.sv
design/camm_ctrl.sv
design/camm_datapath.sv
design/cascaded_attitude_motor_mixer.sv
tb/camm_checker.sv
tb/tb.sv
